// ----- rtl/udwo_pkg.sv -----
// Shared constants for the UTF-8 decoder with byte offsets.
`default_nettype none

package udwo_pkg;

  // Widths of the fixed result fields and the depth of the result run
  localparam int unsigned CpW    = 21;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = 3;

  // Replacement character for bad or cut-off sequences
  localparam logic [CpW-1:0] Repl = 21'h00FFFD;

  // Sequence lengths named by lead byte
  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/utf8_decode_with_offsets.sv -----
// Top level: streaming UTF-8 decoder that tags each code point with its start offset.
// Flow: an accepted byte waits in the input register and is decoded into the result
// register once that register is empty or its last result is being taken.
// Throughput: one byte per cycle while the output is ready and a byte causes at most
// one result; an error flush of n results holds the result register until all are taken.
// Reset: asynchronous, active low; clears decode state, counters and valids.
`default_nettype none

module utf8_decode_with_offsets #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [udwo_pkg::ByteW-1:0]   data_byte_i,
  input  wire logic                         final_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [udwo_pkg::CpW-1:0]          code_point_o,
  output logic [OFFSET_BITS-1:0]            start_offset_o,
  output logic                              string_done_o,
  output logic [OFFSET_BITS-1:0]            total_bytes_o,
  output logic                              run_last_o
);

  import udwo_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};

  function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                    input logic [1:0] k);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + {{(OFFSET_BITS - 1){1'b0}}, k};
    return s[OFFSET_BITS] ? OffMax : s[OFFSET_BITS-1:0];
  endfunction

  // Input register
  logic             ivalid_q, ivalid_d;
  logic [ByteW-1:0] byte_q;
  logic             fin_q;

  // Decode state
  logic [CpW-1:0]         partial_q, partial_d;
  logic [2:0]             exp_q, exp_d;
  logic [1:0]             held_q, held_d;
  logic [OFFSET_BITS-1:0] seq_start_q, seq_start_d;
  logic [OFFSET_BITS-1:0] counter_q, counter_d;

  // Result register: run of up to four results, head at slot zero
  logic [CpW-1:0]         res_cp_q  [MaxRes];
  logic [OFFSET_BITS-1:0] res_off_q [MaxRes];
  logic [CntW-1:0]        cnt_q;
  logic                   run_fin_q;
  logic [OFFSET_BITS-1:0] total_q;

  logic move;
  logic out_take;

  // Combinational decode results
  logic [CpW-1:0]         slot_cp  [MaxRes];
  logic [OFFSET_BITS-1:0] slot_off [MaxRes];
  logic [CntW-1:0]        run_n;
  logic [OFFSET_BITS-1:0] next_off;

  logic           pending;
  logic           is_cont;
  logic [CpW-1:0] partial_ext;
  logic [2:0]     held_ext;
  logic [2:0]     lead_len;
  logic [CpW-1:0] lead_cp;
  logic           lead_parse;
  logic           lead_emit;
  logic [1:0]     lead_idx;

  // Handshakes
  assign out_take    = out_valid_o && out_ready_i;
  assign move        = ivalid_q && ((cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i));
  assign in_ready_o  = !ivalid_q || move;
  assign ivalid_d    = (in_valid_i && in_ready_o) || (ivalid_q && !move);

  // Classify the lead byte
  always_comb begin
    lead_cp  = Repl;
    lead_len = LenOne;
    if (!byte_q[7]) begin
      lead_cp  = {{(CpW - ByteW){1'b0}}, byte_q};
    end else if (byte_q[7:5] == 3'b110) begin
      lead_cp  = {{(CpW - 5){1'b0}}, byte_q[4:0]};
      lead_len = LenTwo;
    end else if (byte_q[7:4] == 4'b1110) begin
      lead_cp  = {{(CpW - 4){1'b0}}, byte_q[3:0]};
      lead_len = LenThree;
    end else if (byte_q[7:3] == 5'b11110) begin
      lead_cp  = {{(CpW - 3){1'b0}}, byte_q[2:0]};
      lead_len = LenFour;
    end
  end

  // Decode one byte against the pending sequence
  always_comb begin
    pending     = (exp_q != '0);
    is_cont     = (byte_q[7:6] == 2'b10);
    partial_ext = {partial_q[CpW-7:0], byte_q[5:0]};
    held_ext    = {1'b0, held_q} + 3'd1;
    next_off    = sat_add(counter_q, 2'd1);

    lead_parse  = !(pending && is_cont);
    lead_emit   = lead_parse && ((lead_len == LenOne) || fin_q);
    lead_idx    = pending ? held_q : 2'd0;

    partial_d   = partial_q;
    exp_d       = exp_q;
    held_d      = held_q;
    seq_start_d = seq_start_q;
    run_n       = '0;

    if (pending && is_cont) begin
      if (held_ext >= exp_q) begin
        run_n       = CntW'(1);
        partial_d   = '0;
        exp_d       = '0;
        held_d      = '0;
        seq_start_d = '0;
      end else if (fin_q) begin
        run_n = held_ext;
      end else begin
        partial_d = partial_ext;
        held_d    = held_ext[1:0];
      end
    end else begin
      // flush what is held, then the byte as a new lead
      run_n = (pending ? {1'b0, held_q} : 3'd0) + {2'b00, lead_emit};
      if (!lead_emit) begin
        partial_d   = lead_cp;
        exp_d       = lead_len;
        held_d      = 2'd1;
        seq_start_d = counter_q;
      end else begin
        partial_d   = '0;
        exp_d       = '0;
        held_d      = '0;
        seq_start_d = '0;
      end
    end

    // end of string returns the decoder to its reset state
    if (fin_q) begin
      partial_d   = '0;
      exp_d       = '0;
      held_d      = '0;
      seq_start_d = '0;
    end
    counter_d = fin_q ? '0 : next_off;

    // fill result slots: replacement at successive offsets, lead at its place
    for (int k = 0; k < MaxRes; k++) begin
      slot_cp[k]  = Repl;
      slot_off[k] = sat_add(seq_start_q, 2'(k));
      if (lead_emit && (2'(k) == lead_idx)) begin
        slot_cp[k]  = (lead_len == LenOne) ? lead_cp : Repl;
        slot_off[k] = counter_q;
      end
    end
    if (pending && is_cont && (held_ext >= exp_q)) begin
      slot_cp[0] = partial_ext;
    end
  end

  // Capture input beats
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      fin_q  <= final_byte_i;
    end
  end

  // Advance control and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivalid_q    <= 1'b0;
      partial_q   <= '0;
      exp_q       <= '0;
      held_q      <= '0;
      seq_start_q <= '0;
      counter_q   <= '0;
      cnt_q       <= '0;
    end else begin
      ivalid_q <= ivalid_d;
      if (move) begin
        partial_q   <= partial_d;
        exp_q       <= exp_d;
        held_q      <= held_d;
        seq_start_q <= seq_start_d;
        counter_q   <= counter_d;
        cnt_q       <= run_n;
      end else if (out_take) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Load a new run or shift the current one toward slot zero
  always_ff @(posedge clk_i) begin
    if (move) begin
      for (int k = 0; k < MaxRes; k++) begin
        res_cp_q[k]  <= slot_cp[k];
        res_off_q[k] <= slot_off[k];
      end
      run_fin_q <= fin_q;
      total_q   <= next_off;
    end else if (out_take) begin
      for (int k = 0; k < MaxRes - 1; k++) begin
        res_cp_q[k]  <= res_cp_q[k+1];
        res_off_q[k] <= res_off_q[k+1];
      end
    end
  end

  // Drive the result beat
  assign out_valid_o    = (cnt_q != '0);
  assign run_last_o     = (cnt_q == CntW'(1));
  assign string_done_o  = run_last_o && run_fin_q;
  assign code_point_o   = res_cp_q[0];
  assign start_offset_o = res_off_q[0];
  assign total_bytes_o  = string_done_o ? total_q : '0;

  // Checks
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRes))
    else $error("result count out of range");

  a_final_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && fin_q |-> run_n != '0)
    else $error("final byte produced no result");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && fin_q |=> counter_q == '0 && exp_q == '0)
    else $error("state not cleared after final byte");

  a_held_below_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q != '0 |-> {1'b0, held_q} < exp_q)
    else $error("pending sequence holds too many bytes");

endmodule

`default_nettype wire
